>>> rtl/core/running_mean_variance_defines.svh
// ----------------------------------------------------------------------------
// running mean and variance: assertion macros
// shared checking helpers for the statistics core
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_VARIANCE_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define RMV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// expression must never be true out of reset
`define RMV_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

>>> rtl/core/rmv_pkg.sv
// ----------------------------------------------------------------------------
// rmv_pkg
// shared types and constants for the running mean and variance core
// ----------------------------------------------------------------------------
package rmv_pkg;

    localparam int DATA_W   = 32;
    localparam int WIDE_W   = 64;
    localparam int OUT_W    = 6 * DATA_W + 2 * WIDE_W;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int COUNT_WIDTH_DEF  = 32;

    // iteration counts of the shared divider
    localparam int MDIV_STEPS = DATA_W + 1;
    localparam int VDIV_STEPS = WIDE_W;
    localparam int STEP_W     = 7;

    // request kinds
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // variance divisor choice
    localparam logic VAR_SAMPLE     = 1'b0;
    localparam logic VAR_POPULATION = 1'b1;

    typedef struct packed {
        logic capture;
        logic start_mdiv;
        logic mean_upd;
        logic mul;
        logic acc;
        logic start_vdiv;
        logic var_take;
        logic var_zero;
        logic start_sqrt;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic skip_welford;
        logic var_needed;
        logic div_busy;
        logic sqrt_busy;
        logic out_busy;
    } sts_t;

endpackage

>>> rtl/core/rmv_ctrl.sv
// ----------------------------------------------------------------------------
// rmv_ctrl
// sequencer for one item: update, mean division, m2 update, variance, sqrt
// ----------------------------------------------------------------------------
module rmv_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  rmv_pkg::sts_t sts,
    output rmv_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_MDIV_GO, S_MDIV_WAIT, S_MEAN, S_MUL, S_ACC,
        S_VDIV_GO, S_VDIV_WAIT, S_SQRT_GO, S_SQRT_WAIT, S_OUT
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_DECIDE;
            S_DECIDE:    state_next = sts.skip_welford ? S_VDIV_GO : S_MDIV_GO;
            S_MDIV_GO:   state_next = S_MDIV_WAIT;
            S_MDIV_WAIT: if (!sts.div_busy) state_next = S_MEAN;
            S_MEAN:      state_next = S_MUL;
            S_MUL:       state_next = S_ACC;
            S_ACC:       state_next = S_VDIV_GO;
            S_VDIV_GO:   state_next = sts.var_needed ? S_VDIV_WAIT : S_SQRT_GO;
            S_VDIV_WAIT: if (!sts.div_busy) state_next = S_SQRT_GO;
            S_SQRT_GO:   state_next = S_SQRT_WAIT;
            S_SQRT_WAIT: if (!sts.sqrt_busy) state_next = S_OUT;
            S_OUT:       if (!sts.out_busy) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // commands to the datapath
    always_comb begin
        cmd            = '0;
        cmd.capture    = (state_reg == S_IDLE) && s_tvalid;
        cmd.start_mdiv = (state_reg == S_MDIV_GO);
        cmd.mean_upd   = (state_reg == S_MEAN);
        cmd.mul        = (state_reg == S_MUL);
        cmd.acc        = (state_reg == S_ACC);
        cmd.start_vdiv = (state_reg == S_VDIV_GO) && sts.var_needed;
        cmd.var_zero   = (state_reg == S_VDIV_GO) && !sts.var_needed;
        cmd.var_take   = (state_reg == S_VDIV_WAIT) && !sts.div_busy;
        cmd.start_sqrt = (state_reg == S_SQRT_GO);
        cmd.out_load   = (state_reg == S_OUT) && !sts.out_busy;
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

>>> rtl/core/rmv_datapath.sv
// ----------------------------------------------------------------------------
// rmv_datapath
// statistics registers, shared restoring divider, multiplier, integer sqrt
// ----------------------------------------------------------------------------
`include "running_mean_variance_defines.svh"

module rmv_datapath #(
    parameter int SAMPLE_WIDTH = rmv_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = rmv_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rmv_pkg::cmd_t              cmd,
    output rmv_pkg::sts_t              sts,
    input  logic                       cfg_valid,
    input  logic                       cfg_wdata,
    input  logic                       in_req,
    input  logic [rmv_pkg::DATA_W-1:0] in_sample,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [rmv_pkg::OUT_W-1:0]  m_tdata
);

    localparam int DW = rmv_pkg::DATA_W;
    localparam int WW = rmv_pkg::WIDE_W;

    logic                    kind_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic signed [DW-1:0]    latest_reg, min_reg, max_reg, mean_reg, x_reg;
    logic signed [WW-1:0]    sum_reg;
    logic [WW-1:0]           accum_reg, prod_reg, var_reg;
    logic signed [DW:0]      delta1_reg;
    logic                    skip_reg;
    logic [DW-1:0]           a1_reg, a2_reg;
    logic [DW-1:0]           d_reg, rem_reg;
    logic [WW-1:0]           quo_reg;
    logic [rmv_pkg::STEP_W-1:0] div_cnt_reg;
    logic [WW-1:0]           sv_reg, sres_reg, sbit_reg;
    logic                    m_tvalid_reg;
    logic [rmv_pkg::OUT_W-1:0] m_tdata_reg;

    logic signed [SAMPLE_WIDTH-1:0] raw;
    logic signed [DW-1:0]    x;
    logic [DW-1:0]           count_ext;
    logic signed [WW:0]      sum_next;
    logic [DW:0]             a1_next;
    logic [DW:0]             rem_sh;
    logic                    ge;
    logic [DW:0]             q_mag;
    logic signed [DW:0]      q_sgn, nmean_next, delta2;
    logic [DW:0]             a2_next;
    logic [WW:0]             accum_next;
    logic [WW-1:0]           strial;

    // sample and sum arithmetic
    always_comb begin
        raw       = in_sample[SAMPLE_WIDTH-1:0];
        x         = DW'(raw);
        count_ext = DW'(count_reg);
        sum_next  = (WW+1)'(sum_reg) + (WW+1)'(x);
        a1_next   = delta1_reg[DW] ? (DW+1)'(-delta1_reg) : (DW+1)'(delta1_reg);
        rem_sh    = {rem_reg, quo_reg[WW-1]};
        ge        = rem_sh >= {1'b0, d_reg};
        q_mag     = quo_reg[DW:0];
        q_sgn     = delta1_reg[DW] ? -$signed(q_mag) : $signed(q_mag);
        nmean_next = (DW+1)'(mean_reg) + q_sgn;
        delta2    = (DW+1)'(x_reg) - nmean_next;
        a2_next   = delta2[DW] ? (DW+1)'(-delta2) : (DW+1)'(delta2);
        accum_next = {1'b0, accum_reg} + {1'b0, prod_reg};
        strial    = sres_reg + sbit_reg;
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= rmv_pkg::VAR_SAMPLE;
        end else if (cfg_valid) begin
            kind_reg <= cfg_wdata;
        end
    end

    // running statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            latest_reg <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            sum_reg    <= '0;
            mean_reg   <= '0;
            accum_reg  <= '0;
        end else if (cmd.capture) begin
            if (in_req == rmv_pkg::REQ_CLEAR) begin
                count_reg  <= '0;
                latest_reg <= '0;
                min_reg    <= '0;
                max_reg    <= '0;
                sum_reg    <= '0;
                mean_reg   <= '0;
                accum_reg  <= '0;
            end else begin
                if (count_reg != '1) count_reg <= count_reg + 1'b1;
                latest_reg <= x;
                if (sum_next[WW] != sum_next[WW-1]) begin
                    sum_reg <= sum_next[WW] ? {1'b1, {(WW-1){1'b0}}}
                                            : {1'b0, {(WW-1){1'b1}}};
                end else begin
                    sum_reg <= sum_next[WW-1:0];
                end
                if (count_reg == '0) begin
                    min_reg  <= x;
                    max_reg  <= x;
                    mean_reg <= x;
                end else begin
                    if (x < min_reg) min_reg <= x;
                    if (x > max_reg) max_reg <= x;
                end
            end
        end else if (cmd.mean_upd) begin
            mean_reg <= nmean_next[DW-1:0];
        end else if (cmd.acc) begin
            accum_reg <= accum_next[WW] ? '1 : accum_next[WW-1:0];
        end
    end

    // item working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg      <= x;
            delta1_reg <= (DW+1)'(x) - (DW+1)'(mean_reg);
            skip_reg   <= (in_req == rmv_pkg::REQ_CLEAR) || (count_reg == '0);
        end
        if (cmd.mean_upd) begin
            a1_reg <= a1_next[DW-1:0];
            a2_reg <= a2_next[DW-1:0];
        end
        if (cmd.mul) prod_reg <= WW'(a1_reg) * WW'(a2_reg);
        if (cmd.var_take) var_reg <= quo_reg;
        if (cmd.var_zero) var_reg <= '0;
    end

    // shared restoring divider, one quotient bit a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.start_mdiv) begin
            quo_reg     <= {a1_next, {(WW-DW-1){1'b0}}};
            d_reg       <= count_ext;
            rem_reg     <= '0;
            div_cnt_reg <= rmv_pkg::STEP_W'(rmv_pkg::MDIV_STEPS);
        end else if (cmd.start_vdiv) begin
            quo_reg     <= accum_reg;
            d_reg       <= (kind_reg == rmv_pkg::VAR_POPULATION) ? count_ext
                                                                : count_ext - 1'b1;
            rem_reg     <= '0;
            div_cnt_reg <= rmv_pkg::STEP_W'(rmv_pkg::VDIV_STEPS);
        end else if (div_cnt_reg != '0) begin
            rem_reg     <= ge ? DW'(rem_sh - {1'b0, d_reg}) : rem_sh[DW-1:0];
            quo_reg     <= {quo_reg[WW-2:0], ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // integer square root, two radicand bits a cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sbit_reg <= '0;
        end else if (cmd.start_sqrt) begin
            sv_reg   <= var_reg;
            sres_reg <= '0;
            sbit_reg <= {2'b01, {(WW-2){1'b0}}};
        end else if (sbit_reg != '0) begin
            if (sv_reg >= strial) begin
                sv_reg   <= sv_reg - strial;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end else begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {sres_reg[DW-1:0], var_reg, mean_reg, sum_reg,
                            max_reg, min_reg, latest_reg, count_ext};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        sts              = '0;
        sts.skip_welford = skip_reg;
        sts.var_needed   = count_reg > COUNT_WIDTH'(1);
        sts.div_busy     = div_cnt_reg != '0;
        sts.sqrt_busy    = sbit_reg != '0;
        sts.out_busy     = m_tvalid_reg && !m_tready;
    end

    `RMV_NEVER(a_min_le_max, (count_reg != '0) && (min_reg > max_reg), "minimum above maximum")
    `RMV_NEVER(a_mean_in_range, (count_reg != '0) && ((mean_reg < min_reg) || (mean_reg > max_reg)), "mean outside sample range")
    `RMV_ASSERT(a_empty_zero, (count_reg == '0) |-> ((sum_reg == '0) && (accum_reg == '0)), "empty statistics not zero")
    `RMV_ASSERT(a_div_start, (cmd.start_mdiv || cmd.start_vdiv) |=> (div_cnt_reg != '0), "divider did not start")

endmodule

>>> rtl/core/running_mean_variance.sv
// A push runs from acceptance to result through the shared restoring divider
// (33 steps for the mean, 64 for the variance) and the 32-step integer square
// root; a clear or a first sample skips the mean step.
// Throughput: one item at a time; the next item is taken once the result is in
// the output register. Reset (aresetn low, synchronous) zeroes all statistics
// and selects sample variance.
// ----------------------------------------------------------------------------
// running_mean_variance
// Welford running count, min, max, sum, mean, variance and deviation
// ----------------------------------------------------------------------------
module running_mean_variance #(
    parameter int SAMPLE_WIDTH = rmv_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = rmv_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // sample[31:0]
    input  logic [rmv_pkg::DATA_W-1:0] s_tdata,
    // req_type
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // sample_count, latest_sample, minimum_value, maximum_value, running_sum,
    // mean_value, variance_value, std_deviation
    output logic [rmv_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_wdata
);

    rmv_pkg::cmd_t cmd;
    rmv_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    rmv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rmv_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_wdata (cfg_wdata),
        .in_req    (s_tuser),
        .in_sample (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

>>> sim/rmv_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmv_checker
// watches the sample, result and register channels, keeps its own copy of
// the running statistics and compares every result beat field by field
// ----------------------------------------------------------------------------
module rmv_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [rmv_pkg::DATA_W-1:0] s_tdata,
    input  logic                       s_tuser,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [rmv_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic                       cfg_wdata,
    output int                         fail_count,
    output int                         pending_count
);

    typedef struct packed {
        logic [63:0] sdev;
        logic [63:0] var_q;
        logic [31:0] mean;
        logic [63:0] total;
        logic [31:0] maxv;
        logic [31:0] minv;
        logic [31:0] latest;
        logic [31:0] count;
    } stats_t;

    stats_t stats_q[$];

    logic            kind_r;
    logic [31:0]     n_r;
    logic signed [63:0] latest_r, min_r, max_r, sum_r, mean_r;
    logic [63:0]     m2_r;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // apply one request beat to the statistics and build the expected result
    task automatic absorb_request(input logic req, input logic [31:0] raw);
        logic signed [63:0] x, d1, d2, nmean;
        logic [63:0] a1, a2, prod, divisor, var_v, root;
        logic first;
        stats_t e;
        if (req == rmv_pkg::REQ_CLEAR) begin
            n_r = 0; latest_r = 0; min_r = 0; max_r = 0;
            sum_r = 0; mean_r = 0; m2_r = 0;
        end else begin
            x = {{32{raw[31]}}, raw};
            first = (n_r == 0);
            if (n_r != 32'hFFFF_FFFF) n_r = n_r + 1;
            latest_r = x;
            // clamp sum at signed 64-bit limits
            if (x > 0 && sum_r > 64'sh7FFF_FFFF_FFFF_FFFF - x)
                sum_r = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (x < 0 && sum_r < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - x)
                sum_r = 64'sh8000_0000_0000_0000;
            else
                sum_r = sum_r + x;
            if (first) begin
                min_r = x; max_r = x; mean_r = x;
            end else begin
                if (x < min_r) min_r = x;
                else if (x > max_r) max_r = x;
                d1 = x - mean_r;
                nmean = mean_r + d1 / $signed({32'd0, n_r});
                d2 = x - nmean;
                a1 = d1 < 0 ? -d1 : d1;
                a2 = d2 < 0 ? -d2 : d2;
                if ((d1 < 0) != (d2 < 0) && a1 != 0 && a2 != 0) prod = 0;
                else prod = a1 * a2;
                if (m2_r > 64'hFFFF_FFFF_FFFF_FFFF - prod) m2_r = '1;
                else m2_r = m2_r + prod;
                mean_r = nmean;
            end
        end
        var_v = 0;
        if (n_r > 1) begin
            divisor = (kind_r == rmv_pkg::VAR_POPULATION) ? {32'd0, n_r}
                                                          : {32'd0, n_r} - 1;
            var_v = m2_r / divisor;
        end
        root     = floor_sqrt(var_v);
        e.count  = n_r;
        e.latest = latest_r[31:0];
        e.minv   = min_r[31:0];
        e.maxv   = max_r[31:0];
        e.total  = sum_r;
        e.mean   = mean_r[31:0];
        e.var_q  = var_v;
        e.sdev   = {32'd0, root[31:0]};
        stats_q.push_back(e);
    endtask

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            fail_count++;
            $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        stats_t got, exp_s;
        if (!aresetn) begin
            kind_r = rmv_pkg::VAR_SAMPLE;
            n_r = 0; latest_r = 0; min_r = 0; max_r = 0;
            sum_r = 0; mean_r = 0; m2_r = 0;
            fail_count = 0;
            stats_q.delete();
            pending_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) kind_r = cfg_wdata;
            if (s_tvalid && s_tready) absorb_request(s_tuser, s_tdata);
            // result beat against the oldest expectation
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (stats_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat expected none actual %h",
                             $time, m_tdata);
                end else begin
                    exp_s = stats_q.pop_front();
                    compare_field("sample_count", exp_s.count, got.count);
                    compare_field("latest_sample", exp_s.latest, got.latest);
                    compare_field("minimum_value", exp_s.minv, got.minv);
                    compare_field("maximum_value", exp_s.maxv, got.maxv);
                    compare_field("running_sum", exp_s.total, got.total);
                    compare_field("mean_value", exp_s.mean, got.mean);
                    compare_field("variance_value", exp_s.var_q, got.var_q);
                    compare_field("std_deviation", exp_s.sdev[31:0], got.sdev[31:0]);
                end
            end
            pending_count = stats_q.size();
        end
    end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives samples and clear requests with random gaps and back-pressure,
// switches the variance divisor between phases and reports the verdict
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [rmv_pkg::DATA_W-1:0]  s_tdata = '0;   // sample[31:0]
    logic                        s_tuser = 1'b0; // req_type
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [rmv_pkg::OUT_W-1:0]   m_tdata;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic                        cfg_wdata = 1'b0;
    int                          fail_count, pending_count;
    int                          idle_cycles = 0;
    bit                          quiet_tail = 0;

    always #5 aclk = ~aclk;

    running_mean_variance u_top (.*);

    rmv_checker u_checker (.*);

    // result side: random back-pressure bursts, none near the end
    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 15);
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    // watchdog on cycles with no beat accepted
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // valid stays high between back-to-back beats and drops only for a gap
    task automatic send_request(input logic req, input logic [31:0] value);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_kind(input logic kind);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_wdata <= kind;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_sample(input int spread);
        case (spread)
            0: return $urandom();
            1: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            default: return $urandom_range(0, 255) << 16;
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, clear, first sample
        send_request(rmv_pkg::REQ_PUSH, 32'h7FFF_FFFF);
        send_request(rmv_pkg::REQ_PUSH, 32'h8000_0000);
        send_request(rmv_pkg::REQ_PUSH, 32'h0000_0000);
        send_request(rmv_pkg::REQ_PUSH, 32'hFFFF_FFFF);
        send_request(rmv_pkg::REQ_PUSH, 32'h0001_0000);
        send_request(rmv_pkg::REQ_CLEAR, 32'hFFFF_FFFF);
        send_request(rmv_pkg::REQ_PUSH, 32'hFFFF_0000);
        send_request(rmv_pkg::REQ_CLEAR, 32'h0);
        send_request(rmv_pkg::REQ_CLEAR, 32'h0);
        for (int i = 0; i < 6; i++) send_request(rmv_pkg::REQ_PUSH, 32'h7FFF_FFFF);
        write_kind(rmv_pkg::VAR_POPULATION);
        for (int i = 0; i < 4; i++) send_request(rmv_pkg::REQ_PUSH, 32'h8000_0000);
        send_request(rmv_pkg::REQ_PUSH, 32'h5555_5555);
        send_request(rmv_pkg::REQ_PUSH, 32'hAAAA_AAAA);
        send_request(rmv_pkg::REQ_CLEAR, 32'h0);
        send_request(rmv_pkg::REQ_PUSH, 32'h0002_8000);

        // random runs of samples with occasional clears, divisor per phase
        for (int phase = 0; phase < 4; phase++) begin
            int spread;
            write_kind(phase[0] ? rmv_pkg::VAR_SAMPLE : rmv_pkg::VAR_POPULATION);
            spread = phase % 3;
            for (int i = 0; i < 95; i++) begin
                if (phase == 3 && i == 60) quiet_tail = 1;
                if ($urandom_range(0, 24) == 0)
                    send_request(rmv_pkg::REQ_CLEAR, $urandom());
                else
                    send_request(rmv_pkg::REQ_PUSH,
                                 random_sample($urandom_range(0, 9) < 2 ? 0 : spread));
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
